// ===== rtl/core/lcdnw_pkg.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble writer: shared package
// Transaction types, operation codes and the control word of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

	// Operation codes of a request.
	localparam logic [2:0] OP_DATA   = 3'd0;
	localparam logic [2:0] OP_CMD    = 3'd1;
	localparam logic [2:0] OP_CURSOR = 3'd2;
	localparam logic [2:0] OP_NUMBER = 3'd3;
	localparam logic [2:0] OP_GLYPH  = 3'd4;

	// Display lines that select a cursor base address.
	localparam logic [1:0] LINE_ONE = 2'd1;
	localparam logic [1:0] LINE_TWO = 2'd2;

	// Fixed byte values.
	localparam logic [7:0] BASE_LINE1 = 8'h80;
	localparam logic [7:0] BASE_LINE2 = 8'hC0;
	localparam logic [7:0] GLYPH_BASE = 8'h40;
	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

	// Digits a 16-bit number can have.
	localparam int DIGIT_SLOTS = 5;

	// Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for any 16-bit x.
	localparam logic [15:0] RECIP_TEN = 16'd52429;
	localparam int RECIP_SHIFT = 19;

	// Extra hold on the last pin state of a byte.
	localparam logic [2:0] TAIL_NONE   = 3'd0;
	localparam logic [2:0] TAIL_CURSOR = 3'd5;
	localparam logic [2:0] TAIL_GLYPH  = 3'd1;

	// Datapath operations.
	localparam logic [1:0] DP_NOP  = 2'd0;
	localparam logic [1:0] DP_LOAD = 2'd1;
	localparam logic [1:0] DP_DIV  = 2'd2;
	localparam logic [1:0] DP_POP  = 2'd3;

	// Hold time selection.
	localparam logic [1:0] HOLD_ZERO = 2'd0;
	localparam logic [1:0] HOLD_ONE  = 2'd1;
	localparam logic [1:0] HOLD_TAIL = 2'd2;

	// Jump conditions.
	localparam logic [2:0] C_NEVER   = 3'd0;
	localparam logic [2:0] C_ALWAYS  = 3'd1;
	localparam logic [2:0] C_NOSTART = 3'd2;
	localparam logic [2:0] C_SKIP    = 3'd3;
	localparam logic [2:0] C_NUM     = 3'd4;
	localparam logic [2:0] C_DIVMORE = 3'd5;
	localparam logic [2:0] C_MORE    = 3'd6;

	localparam int STEP_W = 4;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  byte_value;
		logic [5:0]  column;
		logic [1:0]  line;
		logic [15:0] number;
		logic [2:0]  slot;
	} lcdnw_req_t;

	typedef struct packed {
		logic       reg_select;
		logic       enable;
		logic [3:0] nibble;
		logic [2:0] hold_ms;
		logic       last;
	} lcdnw_res_t;

	// One control word of the microprogram.
	typedef struct packed {
		logic [1:0]        dp_op;
		logic              emit;
		logic              en;
		logic              lo;
		logic [1:0]        hold_sel;
		logic              fin;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} lcdnw_uword_t;

	// Status flags from the datapath used by conditional jumps.
	typedef struct packed {
		logic skip;
		logic is_num;
		logic div_more;
		logic more;
	} lcdnw_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/lcdnw_seq.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble writer: microcode sequencer
// Step counter, control store and jump logic driving the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_seq
	import lcdnw_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire lcdnw_status_t status,
	output logic               busy,
	output logic               capture,
	output lcdnw_uword_t       uw
);

	// Step addresses.
	localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] S_DISP = 4'd1;
	localparam logic [STEP_W-1:0] S_NUMQ = 4'd2;
	localparam logic [STEP_W-1:0] S_EHI1 = 4'd3;
	localparam logic [STEP_W-1:0] S_EHI0 = 4'd4;
	localparam logic [STEP_W-1:0] S_ELO1 = 4'd5;
	localparam logic [STEP_W-1:0] S_ELO0 = 4'd6;
	localparam logic [STEP_W-1:0] S_DONE = 4'd7;
	localparam logic [STEP_W-1:0] S_DIV  = 4'd8;
	localparam logic [STEP_W-1:0] S_POP  = 4'd9;

	// Control store: one word per step.
	function automatic lcdnw_uword_t ucode_rom(input logic [STEP_W-1:0] a);
		lcdnw_uword_t w;
		w = '0;
		case (a)
			S_IDLE: begin
				w.cond = C_NOSTART; w.target = S_IDLE;
			end
			S_DISP: begin
				w.dp_op = DP_LOAD; w.cond = C_SKIP; w.target = S_IDLE;
			end
			S_NUMQ: begin
				w.cond = C_NUM; w.target = S_DIV;
			end
			S_EHI1: begin
				w.emit = 1'b1; w.en = 1'b1; w.hold_sel = HOLD_ONE;
			end
			S_EHI0: begin
				w.emit = 1'b1; w.hold_sel = HOLD_ZERO;
			end
			S_ELO1: begin
				w.emit = 1'b1; w.en = 1'b1; w.lo = 1'b1; w.hold_sel = HOLD_ONE;
			end
			S_ELO0: begin
				w.emit = 1'b1; w.lo = 1'b1; w.hold_sel = HOLD_TAIL; w.fin = 1'b1;
				w.cond = C_MORE; w.target = S_POP;
			end
			S_DONE: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
			end
			S_DIV: begin
				w.dp_op = DP_DIV; w.cond = C_DIVMORE; w.target = S_DIV;
			end
			S_POP: begin
				w.dp_op = DP_POP; w.cond = C_ALWAYS; w.target = S_EHI1;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] step_q;
	logic              take;

	assign uw      = ucode_rom(step_q);
	assign busy    = (step_q != S_IDLE);
	assign capture = start && !busy;

	// Jump condition selection.
	always_comb begin
		case (uw.cond)
			C_NEVER:   take = 1'b0;
			C_ALWAYS:  take = 1'b1;
			C_NOSTART: take = !start;
			C_SKIP:    take = status.skip;
			C_NUM:     take = status.is_num;
			C_DIVMORE: take = status.div_more;
			C_MORE:    take = status.more;
			default:   take = 1'b0;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (take) begin
			step_q <= uw.target;
		end else begin
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lcdnw_dp.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble writer: datapath
// Request capture, byte formation, digit extraction and pin state output.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_dp
	import lcdnw_pkg::*;
#(
	parameter int DEPTH = 5
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         capture,
	input  wire lcdnw_req_t   request,
	input  wire lcdnw_uword_t uw,
	output lcdnw_status_t     status,
	output logic              strobe,
	output lcdnw_res_t        result
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	lcdnw_req_t        req_q;
	logic [7:0]        byte_q;
	logic              rs_q;
	logic [2:0]        tail_q;
	logic [15:0]       val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [3:0]        dig_q [DEPTH];
	logic              strobe_q;
	lcdnw_res_t        result_q;

	logic [31:0]       prod;
	logic [15:0]       quot;
	logic [15:0]       rem_full;
	logic [CNT_W-1:0]  cnt_dec;
	logic [7:0]        cursor_byte;
	logic [2:0]        hold;

	// Division by ten through the reciprocal, remainder by shift-and-add.
	assign prod     = {16'd0, val_q} * {16'd0, RECIP_TEN};
	assign quot     = {3'd0, prod[31:RECIP_SHIFT]};
	assign rem_full = val_q - {quot[12:0], 3'b000} - {quot[14:0], 1'b0};
	assign cnt_dec  = cnt_q - CNT_W'(1);

	// Cursor address from the line base.
	assign cursor_byte = ((req_q.line == LINE_TWO) ? BASE_LINE2 : BASE_LINE1)
		+ {2'b00, req_q.column};

	// Status for conditional jumps.
	assign status.skip = (req_q.operation > OP_GLYPH)
		|| ((req_q.operation == OP_CURSOR)
			&& (req_q.line != LINE_ONE) && (req_q.line != LINE_TWO));
	assign status.is_num   = (req_q.operation == OP_NUMBER);
	assign status.div_more = (quot != 16'd0) && (cnt_q < CNT_W'(DEPTH - 1));
	assign status.more     = (cnt_q != '0);

	// Request capture.
	always_ff @(posedge clk) begin
		if (capture) begin
			req_q <= request;
		end
	end

	// Byte, digit and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (uw.dp_op)
				DP_LOAD: begin
					cnt_q <= '0;
				end
				DP_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				DP_POP: begin
					cnt_q <= cnt_dec;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.dp_op)
			DP_LOAD: begin
				val_q  <= req_q.number;
				rs_q   <= 1'b0;
				tail_q <= TAIL_NONE;
				byte_q <= req_q.byte_value;
				case (req_q.operation)
					OP_DATA: begin
						rs_q <= 1'b1;
					end
					OP_CURSOR: begin
						byte_q <= cursor_byte;
						tail_q <= TAIL_CURSOR;
					end
					OP_GLYPH: begin
						byte_q <= GLYPH_BASE + {2'b00, req_q.slot, 3'b000};
						tail_q <= TAIL_GLYPH;
					end
					default: begin
					end
				endcase
			end
			DP_DIV: begin
				dig_q[cnt_q[IDX_W-1:0]] <= rem_full[3:0];
				val_q <= quot;
			end
			DP_POP: begin
				byte_q <= {ASCII_DIGIT_HI, dig_q[cnt_dec[IDX_W-1:0]]};
				rs_q   <= 1'b1;
				tail_q <= TAIL_NONE;
			end
			default: begin
			end
		endcase
	end

	// Hold time of the current pin state.
	always_comb begin
		case (uw.hold_sel)
			HOLD_ZERO: hold = 3'd0;
			HOLD_ONE:  hold = 3'd1;
			HOLD_TAIL: hold = 3'd2 + tail_q;
			default:   hold = 3'd0;
		endcase
	end

	// Output register: one pin state per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= uw.emit;
		end
	end

	always_ff @(posedge clk) begin
		result_q.reg_select <= rs_q;
		result_q.enable     <= uw.en;
		result_q.nibble     <= uw.lo ? byte_q[3:0] : byte_q[7:4];
		result_q.hold_ms    <= hold;
		result_q.last       <= uw.fin && (cnt_q == '0);
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/char_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble writer
// Turns write requests into timed pin states for a 4-bit character LCD.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and busy stays high
// until the block can take the next one. Each pin state appears on result for
// one cycle with strobe high; the receiver must take it then. The control
// sequencer steps through one control word per clock. A data, command, cursor
// or glyph request sends one byte, a request that sends nothing goes back to
// idle, and a number is sent as its printed digits: one division-by-ten step
// per digit, then five steps per digit to send it. The four strobes for one
// byte come on consecutive cycles. MAX_DIGITS limits how many low digits of a
// number are printed.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_writer
	import lcdnw_pkg::*;
#(
	parameter int MAX_DIGITS = 5
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire lcdnw_req_t request,
	output logic            strobe,
	output lcdnw_res_t      result
);

	localparam int DEPTH = (MAX_DIGITS < DIGIT_SLOTS) ? MAX_DIGITS : DIGIT_SLOTS;

	lcdnw_uword_t  uw;
	lcdnw_status_t status;
	logic          capture;

	// Sequencer.
	lcdnw_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.status  (status),
		.busy    (busy),
		.capture (capture),
		.uw      (uw)
	);

	// Datapath.
	lcdnw_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.capture (capture),
		.request (request),
		.uw      (uw),
		.status  (status),
		.strobe  (strobe),
		.result  (result)
	);

`ifndef SYNTHESIS
	// A request that is taken makes the block busy.
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after taking a request");

	// Every enable pulse is followed by its falling pin state.
	a_en_fall: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.enable |=> strobe && !result.enable)
		else $error("enable high pin state not followed by low one");

	// The final pin state of a request has enable low.
	a_last_low: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !result.enable)
		else $error("final pin state with enable high");

	// Nothing is emitted right after the final pin state.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("pin state emitted after final one");
`endif

endmodule

`default_nettype wire
